### rtl/core/cbuk_pkg.sv
// ----------------------------------------------------------------------------
// cbuk_pkg
// Shared types, register numbers, key values and the write-kind merge
// function for the keyed set/clear/invert register block.
// ----------------------------------------------------------------------------
package cbuk_pkg;

  localparam int DISABLE_COUNT_DEF = 7;
  localparam int LOCK_BIT          = 29;

  localparam int DATA_W     = 32;
  localparam int SEL_W      = 4;
  localparam int KEY_W      = 2;
  localparam int IN_USER_W  = 7;  // mode, reg_select, sub_op
  localparam int OUT_USER_W = 3;  // recognized, key_state

  // Register numbers
  localparam logic [SEL_W-1:0] SEL_MAIN   = 4'd0;
  localparam logic [SEL_W-1:0] SEL_KEY    = 4'd1;
  localparam logic [SEL_W-1:0] SEL_DIS0   = 4'd2;
  localparam logic [SEL_W-1:0] SEL_SECOND = 4'd9;
  localparam logic [SEL_W-1:0] SEL_CACHE  = 4'd10;

  // Unlock sequence values
  localparam logic [DATA_W-1:0] KEY_FIRST  = 32'hAA99_6655;
  localparam logic [DATA_W-1:0] KEY_SECOND = 32'h5566_99AA;

  typedef enum logic [1:0] {
    SUB_DIRECT = 2'd0,
    SUB_SET    = 2'd1,
    SUB_CLEAR  = 2'd2,
    SUB_INVERT = 2'd3
  } sub_op_t;

  typedef struct packed {
    logic              mode;        // 1: write access
    logic [SEL_W-1:0]  reg_select;
    sub_op_t           sub_op;
    logic [DATA_W-1:0] write_data;
  } acc_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              recognized;
    logic [KEY_W-1:0]  key_state;
  } res_t;

  function automatic logic [DATA_W-1:0] merge_write(
    input logic [DATA_W-1:0] cur,
    input logic [DATA_W-1:0] data,
    input sub_op_t           kind
  );
    logic [DATA_W-1:0] val;
    case (kind)
      SUB_DIRECT: val = data;
      SUB_SET:    val = cur | data;
      SUB_CLEAR:  val = cur & ~data;
      SUB_INVERT: val = cur ^ data;
      default:    val = data;
    endcase
    return val;
  endfunction

endpackage

### rtl/core/config_block_with_unlock_key_core.sv
// ----------------------------------------------------------------------------
// config_block_with_unlock_key_core
// Keyed register block with direct/set/clear/invert writes over a stream port.
// ----------------------------------------------------------------------------
// Each input beat is one register access; each access returns exactly one
// result beat. A beat is held in the input register, decoded and applied to
// the register file in a single pass, and its result is captured in the
// output register as soon as that register is empty or being taken. An
// accepted access thus passes the input register and then the output
// register before its result is presented. While a result waits to be taken,
// the input register takes one more access and then holds in_tready low
// until the result moves. Sustained rate is one access per cycle while the
// receiver keeps out_tready high, as each access is read, merged and written
// back in one pass. Writes to the disable words are dropped while the lock
// bit of the main control word is set; the key register always reads zero.
module config_block_with_unlock_key_core
  import cbuk_pkg::*;
#(
  parameter int DISABLE_COUNT = DISABLE_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [31:0] write_data
  input  logic [IN_USER_W-1:0]  in_tuser,   // [0] mode, [4:1] reg_select, [6:5] sub_op
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // [31:0] read_data
  output logic [OUT_USER_W-1:0] out_tuser   // [0] recognized, [2:1] key_state
);

  acc_t              acc_r;
  acc_t              acc_nxt;
  logic              in_valid_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_known_r;
  logic [KEY_W-1:0]  out_key_r;
  logic              advance;
  logic              key_wr;
  logic [KEY_W-1:0]  key_state_nxt;
  res_t              res;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    acc_nxt.mode       = in_tuser[0];
    acc_nxt.reg_select = in_tuser[4:1];
    acc_nxt.sub_op     = sub_op_t'(in_tuser[6:5]);
    acc_nxt.write_data = in_tdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) acc_r <= acc_nxt;
    if (advance) begin
      out_data_r  <= res.read_data;
      out_known_r <= res.recognized;
      out_key_r   <= res.key_state;
    end
  end

  cbuk_key_fsm u_key_fsm (
    .clk           (clk),
    .rst_n         (rst_n),
    .key_wr        (key_wr),
    .key_data      (acc_r.write_data),
    .key_state_nxt (key_state_nxt)
  );

  cbuk_regs #(
    .DISABLE_COUNT (DISABLE_COUNT)
  ) u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (advance),
    .acc           (acc_r),
    .key_state_nxt (key_state_nxt),
    .key_wr        (key_wr),
    .res           (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_key_r, out_known_r};

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed access produced no result beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !advance)
    else $error("pending result overwritten");

endmodule

### rtl/core/cbuk_key_fsm.sv
// ----------------------------------------------------------------------------
// cbuk_key_fsm
// Two-key unlock sequencer. Presents the state that follows the current
// key write so the result beat carries the post-access state.
// ----------------------------------------------------------------------------
module cbuk_key_fsm
  import cbuk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              key_wr,
  input  logic [DATA_W-1:0] key_data,
  output logic [KEY_W-1:0]  key_state_nxt
);

  typedef enum logic [KEY_W-1:0] {
    KS_LOCKED = 2'd0,
    KS_FIRST  = 2'd1,
    KS_OPEN   = 2'd2
  } ks_t;

  ks_t state_r;
  ks_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    if (key_wr) begin
      case (state_r)
        KS_LOCKED: begin
          if (key_data == KEY_FIRST) state_nxt = KS_FIRST;
        end
        KS_FIRST: begin
          state_nxt = (key_data == KEY_SECOND) ? KS_OPEN : KS_LOCKED;
        end
        KS_OPEN: begin
          if (key_data != KEY_FIRST && key_data != KEY_SECOND) state_nxt = KS_LOCKED;
        end
        default: state_nxt = KS_LOCKED;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KS_LOCKED;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign key_state_nxt = KEY_W'(state_nxt);

  a_second_key_opens: assert property (@(posedge clk) disable iff (!rst_n)
    key_wr && state_r == KS_FIRST && key_data == KEY_SECOND |=> state_r == KS_OPEN)
    else $error("second key after first key did not unlock");

  a_hold_without_write: assert property (@(posedge clk) disable iff (!rst_n)
    !key_wr |=> state_r == $past(state_r))
    else $error("key state moved without a key write");

endmodule

### rtl/core/cbuk_regs.sv
// ----------------------------------------------------------------------------
// cbuk_regs
// Register file and access decode. Applies one access per fire and forms
// its result beat from the current register contents.
// ----------------------------------------------------------------------------
module cbuk_regs
  import cbuk_pkg::*;
#(
  parameter int DISABLE_COUNT = DISABLE_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  acc_t              acc,
  input  logic [KEY_W-1:0]  key_state_nxt,
  output logic              key_wr,
  output res_t              res
);

  localparam int IDX_W = (DISABLE_COUNT > 1) ? $clog2(DISABLE_COUNT) : 1;
  localparam logic [SEL_W-1:0] SEL_DIS_LAST = SEL_W'(int'(SEL_DIS0) + DISABLE_COUNT - 1);

  logic [DATA_W-1:0]                    main_r;
  logic [DATA_W-1:0]                    second_r;
  logic [DATA_W-1:0]                    cache_r;
  logic [DISABLE_COUNT-1:0][DATA_W-1:0] dis_r;

  logic              wr;
  logic              is_dis;
  logic              locked;
  logic [IDX_W-1:0]  dis_idx;
  logic              known;
  logic [DATA_W-1:0] rd;

  assign wr      = fire && acc.mode;
  assign is_dis  = (acc.reg_select >= SEL_DIS0) && (acc.reg_select <= SEL_DIS_LAST);
  assign dis_idx = IDX_W'(acc.reg_select - SEL_DIS0);
  assign locked  = main_r[LOCK_BIT];
  assign key_wr  = wr && (acc.reg_select == SEL_KEY);

  always_comb begin
    known = 1'b1;
    rd    = '0;
    if (acc.reg_select == SEL_MAIN) begin
      rd = main_r;
    end else if (acc.reg_select == SEL_KEY) begin
      rd = '0;
    end else if (is_dis) begin
      rd = dis_r[dis_idx];
    end else if (acc.reg_select == SEL_SECOND) begin
      rd = second_r;
    end else if (acc.reg_select == SEL_CACHE) begin
      rd = cache_r;
    end else begin
      known = 1'b0;
    end
  end

  assign res.read_data  = acc.mode ? '0 : rd;
  assign res.recognized = known;
  assign res.key_state  = key_state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_r   <= '0;
      second_r <= '0;
      cache_r  <= '0;
      dis_r    <= '0;
    end else if (wr) begin
      if (acc.reg_select == SEL_MAIN) begin
        main_r <= merge_write(main_r, acc.write_data, acc.sub_op);
      end
      if (acc.reg_select == SEL_SECOND) begin
        second_r <= merge_write(second_r, acc.write_data, acc.sub_op);
      end
      if (acc.reg_select == SEL_CACHE) begin
        cache_r <= merge_write(cache_r, acc.write_data, acc.sub_op);
      end
      // drop disable-word writes while the lock bit is set
      for (int i = 0; i < DISABLE_COUNT; i++) begin
        if (is_dis && !locked && dis_idx == IDX_W'(i)) begin
          dis_r[i] <= merge_write(dis_r[i], acc.write_data, acc.sub_op);
        end
      end
    end
  end

  a_read_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !acc.mode |=> $stable(main_r) && $stable(second_r) && $stable(cache_r)
                          && $stable(dis_r))
    else $error("read access changed register contents");

  a_locked_dis_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr && is_dis && locked |=> $stable(dis_r))
    else $error("disable word written while locked");

  a_unknown_reads_zero: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (!known || acc.reg_select == SEL_KEY) |-> res.read_data == '0)
    else $error("key or unimplemented register returned nonzero data");

endmodule

### tb/tb_config_block_with_unlock_key_core.sv
// ----------------------------------------------------------------------------
// tb_config_block_with_unlock_key_core
// Stream-level check of the keyed set/clear/invert register block.
// ----------------------------------------------------------------------------
// Register accesses are queued up front: a directed opening and then random
// traffic that favors well-formed unlock sequences. A clocked driver offers
// them in bursts. A scoreboard predicts each accepted access from its own copy
// of the register file and key state, and compares every result beat in
// order. The receiver stalls on a phase pattern and holds off twice for a
// long stretch. The sender drains the block completely a few times.
// ----------------------------------------------------------------------------
module tb_config_block_with_unlock_key_core;
  import cbuk_pkg::*;

  localparam int  IDLE_LIMIT = 2000;
  localparam int  RAND_ITEMS = 800;
  localparam int  DIS_IDX_W  = $clog2(DISABLE_COUNT_DEF);
  localparam bit  ACC_READ   = 1'b0;
  localparam bit  ACC_WRITE  = 1'b1;
  localparam logic [SEL_W-1:0]  SEL_LAST  = 4'hF;
  localparam logic [DATA_W-1:0] LOCK_MASK = 32'(1) << LOCK_BIT;

  typedef enum logic [KEY_W-1:0] {
    LK_LOCKED = 2'd0,
    LK_FIRST  = 2'd1,
    LK_OPEN   = 2'd2
  } lock_state_t;

  typedef struct {
    acc_t acc;
    bit   wait_idle;  // hold until every result is back before offering
  } pend_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_W-1:0]     in_tdata  = '0;  // [31:0] write_data
  logic [IN_USER_W-1:0]  in_tuser  = '0;  // [0] mode, [4:1] reg_select, [6:5] sub_op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_W-1:0]     out_tdata;       // [31:0] read_data
  logic [OUT_USER_W-1:0] out_tuser;       // [0] recognized, [2:1] key_state

  pend_t access_q[$];
  res_t  pending_results[$];
  logic  results_drained = 1'b1;
  int    err_cnt = 0;

  // Shadow register file
  logic [DATA_W-1:0] ctl_main, ctl_second, ctl_cache;
  logic [DATA_W-1:0] dis_word [DISABLE_COUNT_DEF];
  lock_state_t       key_st;

  // Sender and receiver pacing
  int burst_left = 0, gap_left = 0;
  int rx_cyc = 0, rx_taken = 0, hold_left = 0, last_hold_at = -1;

  config_block_with_unlock_key_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DATA_W-1:0] merge_bits(
    input logic [DATA_W-1:0] cur,
    input logic [DATA_W-1:0] data,
    input sub_op_t           kind
  );
    case (kind)
      SUB_SET:    return cur | data;
      SUB_CLEAR:  return cur & ~data;
      SUB_INVERT: return cur ^ data;
      default:    return data;
    endcase
  endfunction

  function automatic void add_access(
    input bit                wr,
    input logic [SEL_W-1:0]  sel,
    input sub_op_t           kind,
    input logic [DATA_W-1:0] data,
    input bit                hold = 1'b0
  );
    pend_t p;
    p.acc.mode       = wr;
    p.acc.reg_select = sel;
    p.acc.sub_op     = kind;
    p.acc.write_data = data;
    p.wait_idle      = hold;
    access_q.push_back(p);
  endfunction

  // Driver: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (access_q.size() == 0 ||
                   (access_q[0].wait_idle && (in_tvalid || !results_drained))) begin
        in_tvalid <= 1'b0;
      end else begin
        pend_t p;
        p = access_q.pop_front();
        in_tdata  <= p.acc.write_data;
        in_tuser  <= {p.acc.sub_op, p.acc.reg_select, p.acc.mode};
        in_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: phase-based stall pattern plus two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cyc++;
      if (out_tvalid && out_tready) rx_taken++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if ((rx_taken == 150 || rx_taken == 600) && last_hold_at != rx_taken) begin
        last_hold_at = rx_taken;
        hold_left    = 100;
        out_tready   <= 1'b0;
      end else begin
        case (rx_cyc[8:6])
          3'd0, 3'd1: out_tready <= 1'b1;
          3'd3:       out_tready <= ($urandom_range(0, 3) == 0);
          3'd4:       out_tready <= (rx_cyc[1:0] != 2'd0);
          3'd5:       out_tready <= ($urandom_range(0, 9) != 0);
          default:    out_tready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Scoreboard: predict on input beats, compare on result beats
  always @(posedge clk) begin : scoreboard
    acc_t                 acc;
    res_t                 want, got;
    bit                   is_dis;
    logic [DIS_IDX_W-1:0] dis_i;
    if (!rst_n) begin
      ctl_main   = '0;
      ctl_second = '0;
      ctl_cache  = '0;
      foreach (dis_word[i]) dis_word[i] = '0;
      key_st     = LK_LOCKED;
    end else begin
      if (in_tvalid && in_tready) begin
        acc    = acc_t'({in_tuser[0], in_tuser[4:1], in_tuser[6:5], in_tdata});
        want   = '0;
        want.recognized = 1'b1;
        is_dis = acc.reg_select >= SEL_DIS0 &&
                 acc.reg_select < SEL_DIS0 + DISABLE_COUNT_DEF;
        dis_i  = DIS_IDX_W'(acc.reg_select - SEL_DIS0);
        if (acc.reg_select == SEL_MAIN) begin
          if (acc.mode) ctl_main = merge_bits(ctl_main, acc.write_data, acc.sub_op);
          else want.read_data = ctl_main;
        end else if (acc.reg_select == SEL_KEY) begin
          if (acc.mode) begin
            case (key_st)
              LK_LOCKED: if (acc.write_data == KEY_FIRST) key_st = LK_FIRST;
              LK_FIRST:  key_st = (acc.write_data == KEY_SECOND) ? LK_OPEN : LK_LOCKED;
              default:
                if (acc.write_data != KEY_FIRST && acc.write_data != KEY_SECOND)
                  key_st = LK_LOCKED;
            endcase
          end
        end else if (is_dis) begin
          if (!acc.mode) begin
            want.read_data = dis_word[dis_i];
          end else if (!ctl_main[LOCK_BIT]) begin
            dis_word[dis_i] = merge_bits(dis_word[dis_i], acc.write_data, acc.sub_op);
          end
        end else if (acc.reg_select == SEL_SECOND) begin
          if (acc.mode) ctl_second = merge_bits(ctl_second, acc.write_data, acc.sub_op);
          else want.read_data = ctl_second;
        end else if (acc.reg_select == SEL_CACHE) begin
          if (acc.mode) ctl_cache = merge_bits(ctl_cache, acc.write_data, acc.sub_op);
          else want.read_data = ctl_cache;
        end else begin
          want.recognized = 1'b0;
        end
        want.key_state = key_st;
        pending_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata, out_tuser[0], out_tuser[2:1]};
        if (pending_results.size() == 0) begin
          $error("result beat with no access outstanding: tdata %h tuser %b",
                 out_tdata, out_tuser);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            err_cnt++;
          end
          if (got.recognized !== want.recognized) begin
            $error("recognized: expected %b, got %b", want.recognized, got.recognized);
            err_cnt++;
          end
          if (got.key_state !== want.key_state) begin
            $error("key_state: expected %0d, got %0d", want.key_state, got.key_state);
            err_cnt++;
          end
        end
      end
    end
    results_drained <= (pending_results.size() == 0);
  end

  // Watchdog: end the run if no beat moves for too long
  initial begin
    int idle_cyc;
    idle_cyc = 0;
    while (idle_cyc < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cyc = 0;
      else idle_cyc++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] data;
    int                dsel;
    bit                hold;

    // Disable words open, then locked, then open again
    add_access(ACC_WRITE, SEL_DIS0, SUB_DIRECT, '1);
    add_access(ACC_WRITE, SEL_W'(SEL_DIS0 + 6), SUB_SET, 32'h0000_0001);
    add_access(ACC_READ, SEL_DIS0, SUB_DIRECT, '0);
    add_access(ACC_WRITE, SEL_MAIN, SUB_DIRECT, LOCK_MASK);
    add_access(ACC_WRITE, SEL_W'(SEL_DIS0 + 3), SUB_DIRECT, 32'hDEAD_BEEF);
    add_access(ACC_READ, SEL_W'(SEL_DIS0 + 3), SUB_SET, '0);
    add_access(ACC_WRITE, SEL_MAIN, SUB_CLEAR, LOCK_MASK);
    add_access(ACC_WRITE, SEL_W'(SEL_DIS0 + 3), SUB_INVERT, 32'hFFFF_0000);
    add_access(ACC_READ, SEL_W'(SEL_DIS0 + 3), SUB_CLEAR, '0);
    // Control words with set, invert and clear writes
    add_access(ACC_WRITE, SEL_SECOND, SUB_SET, 32'h8000_0001);
    add_access(ACC_WRITE, SEL_CACHE, SUB_INVERT, '1);
    add_access(ACC_WRITE, SEL_CACHE, SUB_CLEAR, 32'h0F0F_0F0F);
    add_access(ACC_READ, SEL_SECOND, SUB_INVERT, '1);
    add_access(ACC_READ, SEL_CACHE, SUB_DIRECT, '0);
    // Unimplemented numbers
    add_access(ACC_READ, SEL_LAST, SUB_DIRECT, '0);
    add_access(ACC_WRITE, SEL_W'(SEL_CACHE + 1), SUB_DIRECT, '1);
    // Key sequences: repeated first key relocks, second key unlocks
    add_access(ACC_WRITE, SEL_KEY, SUB_DIRECT, KEY_FIRST);
    add_access(ACC_WRITE, SEL_KEY, SUB_SET, KEY_FIRST);
    add_access(ACC_WRITE, SEL_KEY, SUB_CLEAR, KEY_FIRST);
    add_access(ACC_WRITE, SEL_KEY, SUB_INVERT, KEY_SECOND);
    add_access(ACC_WRITE, SEL_KEY, SUB_DIRECT, KEY_FIRST);
    add_access(ACC_WRITE, SEL_KEY, SUB_DIRECT, KEY_SECOND);
    add_access(ACC_READ, SEL_KEY, SUB_DIRECT, '1);
    add_access(ACC_WRITE, SEL_KEY, SUB_DIRECT, '0);
    add_access(ACC_READ, SEL_MAIN, SUB_DIRECT, '0);

    while (access_q.size() < 25 + RAND_ITEMS) begin
      hold = (access_q.size() % 200 == 25);
      dsel = $urandom_range(0, 7);
      data = (dsel == 0) ? '0 : (dsel == 1) ? '1 : (dsel == 2) ? LOCK_MASK : $urandom();
      case ($urandom_range(0, 9))
        0: begin
          add_access(ACC_WRITE, SEL_KEY, sub_op_t'($urandom_range(0, 3)), KEY_FIRST, hold);
          add_access(ACC_WRITE, SEL_KEY, sub_op_t'($urandom_range(0, 3)),
                     ($urandom_range(0, 3) == 0) ? data : KEY_SECOND);
        end
        1: begin
          dsel = $urandom_range(0, 2);
          add_access(1'($urandom_range(0, 1)), SEL_KEY, sub_op_t'($urandom_range(0, 3)),
                     (dsel == 0) ? KEY_FIRST : (dsel == 1) ? KEY_SECOND : data, hold);
        end
        2: add_access(1'($urandom_range(0, 1)),
                      SEL_W'($urandom_range(SEL_CACHE + 1, SEL_LAST)),
                      sub_op_t'($urandom_range(0, 3)), data, hold);
        default:
          add_access(1'($urandom_range(0, 1)), SEL_W'($urandom_range(SEL_MAIN, SEL_CACHE)),
                     sub_op_t'($urandom_range(0, 3)), data, hold);
      endcase
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Sample on the falling edge so the driver's updates have settled
    do @(negedge clk); while (access_q.size() != 0 || in_tvalid);
    do @(negedge clk); while (!results_drained || out_tvalid);
    repeat (8) @(posedge clk);

    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/cbuk_pkg.sv
rtl/core/cbuk_key_fsm.sv
rtl/core/cbuk_regs.sv
rtl/core/config_block_with_unlock_key_core.sv
tb/tb_config_block_with_unlock_key_core.sv
